[hw/rtl/weighted_embedding_gather_sum_top_macros.svh]
// Assertion macros shared by the weighted embedding gather-sum RTL.
`ifndef WEIGHTED_EMBEDDING_GATHER_SUM_TOP_MACROS_SVH
`define WEIGHTED_EMBEDDING_GATHER_SUM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define WEGS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while reset is high.
`define WEGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define WEGS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define WEGS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/wegs_pkg.sv]
// Shared types and constants of the weighted embedding gather-sum block.
package wegs_pkg;

  localparam int MAX_EMIT = 16;
  localparam int EIDX_W   = 4;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 48;
  localparam int DIM_W    = 5;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_GATHER = 1'b1;

  // Tag that travels with one element through the multiply-accumulate pipeline.
  typedef struct packed {
    logic              valid;
    logic [EIDX_W-1:0] idx;
  } mac_ctl_t;

endpackage

[hw/rtl/wegs_table.sv]
// Single-port embedding table memory with registered read data.
module wegs_table
  import wegs_pkg::*;
#(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [ADDR_W-1:0]       addr,
  input  logic signed [VAL_W-1:0] wdata,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/wegs_mac.sv]
// Shared multiply-accumulate unit: registered product, then a saturating add.
module wegs_mac
  import wegs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                issue,
  input  logic signed [VAL_W-1:0] tbl_data,
  input  logic signed [VAL_W-1:0] weight,
  input  logic signed [ACC_W-1:0] acc_in,
  output mac_ctl_t                wr,
  output logic signed [ACC_W-1:0] sum,
  output logic                    ovf,
  output logic                    busy
);

  mac_ctl_t                 rd_ctl;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W:0]    wide;

  // rd_ctl lines up with the table read data, wr with the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
      wr     <= '0;
    end else begin
      rd_ctl <= issue;
      wr     <= rd_ctl;
    end
    prod <= tbl_data * weight;
  end

  always_comb begin
    wide = {acc_in[ACC_W-1], acc_in} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
    ovf  = wide[ACC_W] ^ wide[ACC_W-1];
    if (ovf) begin
      sum = wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum = wide[ACC_W-1:0];
    end
  end

  assign busy = rd_ctl.valid | wr.valid;

endmodule

[hw/rtl/weighted_embedding_gather_sum_top.sv]
// Weighted embedding gather-sum: table, sequencer, accumulator and result stage.
// A load request produces no result. A gather request is accepted, makes one table read
// per element of the used dimension D and then waits until the MAC pipeline is empty.
// A last gather then emits one result per element, holding while the output stalls.
// Reset is synchronous and clears control, the accumulator and the marks, not the table.
`include "weighted_embedding_gather_sum_top_macros.svh"

module weighted_embedding_gather_sum_top
  import wegs_pkg::*;
#(
  parameter int TABLE_ROWS = 1024,
  parameter int VEC_DIM    = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [9:0]              load_row,
  input  logic [3:0]              load_col,
  input  logic signed [VAL_W-1:0] load_value,
  input  logic [9:0]              gather_row,
  input  logic signed [VAL_W-1:0] weight,
  input  logic                    last_in_bag,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [EIDX_W-1:0]       element_index,
  output logic signed [ACC_W-1:0] sum_value,
  output logic                    saturated,
  output logic                    last_element,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [DIM_W-1:0]        dim_in_use
);

  localparam int DEPTH  = TABLE_ROWS * VEC_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Only the first min(VEC_DIM, 16) elements are ever accumulated or emitted.
  localparam int LIM    = (VEC_DIM < MAX_EMIT) ? VEC_DIM : MAX_EMIT;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t                  state;
  logic [DIM_W-1:0]        dim_reg;
  logic [EIDX_W-1:0]       dim_last;
  logic [EIDX_W-1:0]       cnt;
  logic [9:0]              row_q;
  logic signed [VAL_W-1:0] weight_q;
  logic                    last_q;

  // Accumulator vector; an entry whose valid bit is clear reads as zero.
  logic signed [ACC_W-1:0] acc [MAX_EMIT];
  logic [MAX_EMIT-1:0]     acc_vld;
  logic [MAX_EMIT-1:0]     sat;
  logic [EIDX_W-1:0]       acc_idx;
  logic signed [ACC_W-1:0] acc_rd;

  logic                    in_acc;
  logic                    load_ok;
  logic                    gather_ok;
  logic                    tbl_we;
  logic [ADDR_W-1:0]       tbl_addr;
  logic signed [VAL_W-1:0] tbl_rdata;

  mac_ctl_t                issue;
  mac_ctl_t                mac_wr;
  logic signed [ACC_W-1:0] mac_sum;
  logic                    mac_ovf;
  logic                    mac_busy;

  logic                    emit_ld;
  logic                    emit_last;

  // Used dimension, clamped to [1, LIM], kept as its last index.
  always_comb begin
    if (dim_reg == '0) begin
      dim_last = '0;
    end else if (32'(dim_reg) > LIM) begin
      dim_last = EIDX_W'(LIM - 1);
    end else begin
      dim_last = EIDX_W'(dim_reg - 5'd1);
    end
  end

  // The block takes a new request only while the sequencer is idle.
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Loads outside the table are dropped; gathers outside it add nothing.
  assign load_ok   = (32'(load_row) < TABLE_ROWS) && (32'(load_col) < VEC_DIM);
  assign gather_ok = (32'(gather_row) < TABLE_ROWS);

  // The single memory port writes during a load and reads one element a cycle in S_READ.
  assign tbl_we = in_acc && (op == OP_LOAD) && load_ok;

  always_comb begin
    if (state == S_READ) begin
      tbl_addr = ADDR_W'(row_q) * ADDR_W'(VEC_DIM) + ADDR_W'(cnt);
    end else begin
      tbl_addr = ADDR_W'(load_row) * ADDR_W'(VEC_DIM) + ADDR_W'(load_col);
    end
  end

  wegs_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (load_value),
    .rdata (tbl_rdata)
  );

  assign issue.valid = (state == S_READ);
  assign issue.idx   = cnt;

  // The accumulator is read by the MAC write-back during a gather and by the emit
  // counter while results go out; the two never overlap.
  assign acc_idx = (state == S_EMIT) ? cnt : mac_wr.idx;
  assign acc_rd  = acc_vld[acc_idx] ? acc[acc_idx] : '0;

  wegs_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .tbl_data (tbl_rdata),
    .weight   (weight_q),
    .acc_in   (acc_rd),
    .wr       (mac_wr),
    .sum      (mac_sum),
    .ovf      (mac_ovf),
    .busy     (mac_busy)
  );

  // A result is loaded whenever the output register is empty or being taken.
  assign emit_ld   = (state == S_EMIT) && (!out_valid || !out_stall);
  assign emit_last = (cnt == dim_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dim_reg   <= DIM_RESET;
      cnt       <= '0;
      last_q    <= 1'b0;
      acc_vld   <= '0;
      sat       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dim_reg <= dim_in_use;
      end

      // A taken result empties the register unless the next one moves in.
      if (out_valid && !out_stall && !emit_ld) begin
        out_valid <= 1'b0;
      end

      if (mac_wr.valid) begin
        acc_vld[mac_wr.idx] <= 1'b1;
        sat[mac_wr.idx]     <= sat[mac_wr.idx] | mac_ovf;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && (op == OP_GATHER)) begin
            last_q <= last_in_bag;
            cnt    <= '0;
            state  <= gather_ok ? S_READ : S_DRAIN;
          end
        end
        S_READ: begin
          if (cnt == dim_last) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_DRAIN: begin
          if (!mac_busy) begin
            cnt   <= '0;
            state <= last_q ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_ld) begin
            out_valid     <= 1'b1;
            element_index <= cnt;
            sum_value     <= acc_rd;
            saturated     <= sat[cnt];
            last_element  <= emit_last;
            if (emit_last) begin
              acc_vld <= '0;
              sat     <= '0;
              state   <= S_IDLE;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request operands and accumulator data.
  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_GATHER)) begin
      row_q    <= gather_row;
      weight_q <= weight;
    end
    if (mac_wr.valid) begin
      acc[mac_wr.idx] <= mac_sum;
    end
  end

  // The MAC writes the accumulator only while a gather is in progress.
  `WEGS_ASSERT_IMPLY(a_mac_in_gather, clk, rst, mac_wr.valid, (state == S_READ || state == S_DRAIN))
  // Emitting the final element leaves the accumulator and the marks cleared.
  `WEGS_ASSERT_NEXT(a_clear_after_emit, clk, rst, emit_ld && emit_last, (acc_vld == '0 && sat == '0))
  // A taken result that is not the last is followed at once by the next element.
  `WEGS_ASSERT_NEXT(a_emit_order, clk, rst, out_valid && !out_stall && !last_element, (out_valid && element_index == 4'($past(element_index) + 4'd1)))

endmodule
